/* rtl/ntc_pkg.sv */
package ntc_pkg;

	// Numeric type codes.
	localparam logic [3:0] T_I8  = 4'd0;
	localparam logic [3:0] T_I16 = 4'd1;
	localparam logic [3:0] T_I32 = 4'd2;
	localparam logic [3:0] T_I64 = 4'd3;
	localparam logic [3:0] T_U8  = 4'd4;
	localparam logic [3:0] T_U16 = 4'd5;
	localparam logic [3:0] T_U32 = 4'd6;
	localparam logic [3:0] T_U64 = 4'd7;
	localparam logic [3:0] T_F32 = 4'd8;
	localparam logic [3:0] T_F64 = 4'd9;

	// Value classes.
	localparam logic [1:0] CLS_ZERO = 2'd0;
	localparam logic [1:0] CLS_FIN  = 2'd1;
	localparam logic [1:0] CLS_INF  = 2'd2;
	localparam logic [1:0] CLS_NAN  = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_EXACT = 3'd0;
	localparam logic [2:0] ST_INEX  = 3'd1;
	localparam logic [2:0] ST_SAT   = 3'd2;
	localparam logic [2:0] ST_NAN   = 3'd3;
	localparam logic [2:0] ST_BAD   = 3'd4;

	// Decoded exact value: finite value is mant * 2^exp.
	typedef struct packed {
		logic               bad;
		logic [3:0]         tgt;
		logic [1:0]         cls;
		logic               neg;
		logic [63:0]        mant;
		logic signed [12:0] exp;
	} dec_t;

	// Normalized value: leading one at bit 63, e is the exponent of that bit.
	typedef struct packed {
		logic               bad;
		logic [3:0]         tgt;
		logic [1:0]         cls;
		logic               neg;
		logic [63:0]        nm;
		logic signed [12:0] e;
	} nrm_t;

	// Aligned significand with round and sticky bits.
	typedef struct packed {
		logic               bad;
		logic [3:0]         tgt;
		logic [1:0]         cls;
		logic               neg;
		logic [63:0]        m;
		logic               rbit;
		logic               sticky;
		logic signed [12:0] eo;
		logic               big;
	} aln_t;

	typedef struct packed {
		logic [63:0] result;
		logic [2:0]  status;
	} res_t;

endpackage

/* rtl/ntc_decode_stage.sv */
module ntc_decode_stage import ntc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [3:0]  source_type,
	input  logic [63:0] source_bits,
	input  logic [3:0]  target_type,
	output dec_t        dec_s1
);

	dec_t d;
	logic [63:0] v;

	// Split the source into sign, significand and exponent.
	always_comb begin
		d = '0;
		v = '0;
		d.tgt = target_type;
		d.bad = (source_type > T_F64) || (target_type > T_F64);
		if (source_type == T_F32) begin
			d.neg = source_bits[31];
			if (source_bits[30:23] == 8'hff) begin
				d.cls = (source_bits[22:0] != '0) ? CLS_NAN : CLS_INF;
				d.mant = {source_bits[22:0], 41'd0};
			end else if (source_bits[30:23] == 8'h00) begin
				d.cls = (source_bits[22:0] != '0) ? CLS_FIN : CLS_ZERO;
				d.mant = {41'd0, source_bits[22:0]};
				d.exp = -13'sd149;
			end else begin
				d.cls = CLS_FIN;
				d.mant = {40'd0, 1'b1, source_bits[22:0]};
				d.exp = $signed({5'd0, source_bits[30:23]}) - 13'sd150;
			end
		end else if (source_type == T_F64) begin
			d.neg = source_bits[63];
			if (source_bits[62:52] == 11'h7ff) begin
				d.cls = (source_bits[51:0] != '0) ? CLS_NAN : CLS_INF;
				d.mant = {source_bits[51:0], 12'd0};
			end else if (source_bits[62:52] == 11'h000) begin
				d.cls = (source_bits[51:0] != '0) ? CLS_FIN : CLS_ZERO;
				d.mant = {12'd0, source_bits[51:0]};
				d.exp = -13'sd1074;
			end else begin
				d.cls = CLS_FIN;
				d.mant = {11'd0, 1'b1, source_bits[51:0]};
				d.exp = $signed({2'd0, source_bits[62:52]}) - 13'sd1075;
			end
		end else begin
			case (source_type[1:0])
				2'd0: v = {{56{source_bits[7] & ~source_type[2]}}, source_bits[7:0]};
				2'd1: v = {{48{source_bits[15] & ~source_type[2]}}, source_bits[15:0]};
				2'd2: v = {{32{source_bits[31] & ~source_type[2]}}, source_bits[31:0]};
				default: v = source_bits;
			endcase
			d.neg = ~source_type[2] & v[63];
			d.mant = d.neg ? (64'd0 - v) : v;
			d.cls = (v != '0) ? CLS_FIN : CLS_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= d;
		end
	end

endmodule

/* rtl/ntc_norm_stage.sv */
module ntc_norm_stage import ntc_pkg::*; (
	input  logic clk,
	input  logic en,
	input  dec_t dec_s1,
	output nrm_t nrm_s2
);

	logic [5:0] lz;
	nrm_t n;

	// Leading zero count of the significand.
	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (dec_s1.mant[i]) begin
				lz = 6'(63 - i);
			end
		end
	end

	// Move the leading one to the top bit.
	always_comb begin
		n.bad = dec_s1.bad;
		n.tgt = dec_s1.tgt;
		n.cls = dec_s1.cls;
		n.neg = dec_s1.neg;
		n.nm = (dec_s1.cls == CLS_FIN) ? (dec_s1.mant << lz) : dec_s1.mant;
		n.e = dec_s1.exp + 13'sd63 - $signed({7'd0, lz});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s2 <= n;
		end
	end

endmodule

/* rtl/ntc_align_stage.sv */
module ntc_align_stage import ntc_pkg::*; (
	input  logic clk,
	input  logic en,
	input  nrm_t nrm_s2,
	output aln_t aln_s3
);

	logic signed [13:0] sh_w;
	logic [6:0] sh;
	logic [6:0] ms;
	logic [63:0] lowmask;
	aln_t a;

	// Pick the right shift for the target and apply it with round and sticky.
	always_comb begin
		a.bad = nrm_s2.bad;
		a.tgt = nrm_s2.tgt;
		a.cls = nrm_s2.cls;
		a.neg = nrm_s2.neg;
		a.eo = nrm_s2.e;
		a.big = 1'b0;
		if (nrm_s2.tgt == T_F32) begin
			if (nrm_s2.e >= -13'sd126) begin
				sh_w = 14'sd40;
			end else begin
				sh_w = 14'sd40 + (-14'sd126 - 14'(nrm_s2.e));
				a.eo = -13'sd126;
			end
		end else if (nrm_s2.tgt == T_F64) begin
			if (nrm_s2.e >= -13'sd1022) begin
				sh_w = 14'sd11;
			end else begin
				sh_w = 14'sd11 + (-14'sd1022 - 14'(nrm_s2.e));
				a.eo = -13'sd1022;
			end
		end else begin
			sh_w = 14'sd63 - 14'(nrm_s2.e);
			a.big = nrm_s2.e > 13'sd63;
		end
		if (sh_w < 0) begin
			sh = 7'd0;
		end else if (sh_w > 14'sd127) begin
			sh = 7'd127;
		end else begin
			sh = sh_w[6:0];
		end
		ms = 7'd65 - sh;
		if (sh == 7'd0) begin
			lowmask = '0;
		end else if (sh >= 7'd65) begin
			lowmask = '1;
		end else begin
			lowmask = 64'hffff_ffff_ffff_ffff >> ms;
		end
		a.m = (sh >= 7'd64) ? 64'd0 : (nrm_s2.nm >> sh[5:0]);
		a.rbit = (sh != 7'd0) && (sh <= 7'd64) && nrm_s2.nm[6'(sh - 7'd1)];
		a.sticky = (nrm_s2.nm & lowmask) != '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aln_s3 <= a;
		end
	end

endmodule

/* rtl/ntc_round_stage.sv */
module ntc_round_stage import ntc_pkg::*; (
	input  logic clk,
	input  logic en,
	input  aln_t aln_s3,
	output res_t res_s4
);

	logic [54:0] mr;
	logic signed [13:0] eb;
	logic signed [13:0] biased;
	logic [63:0] posmax;
	logic [63:0] negmax;
	logic [63:0] wm;
	logic [63:0] mag;
	logic over;
	logic inexact;
	logic is_f64;
	res_t r;

	// Round to nearest even for floats, saturate for integers, then pack.
	always_comb begin
		r = '0;
		is_f64 = aln_s3.tgt == T_F64;
		inexact = aln_s3.rbit | aln_s3.sticky;
		mr = {1'b0, aln_s3.m[53:0]} + 55'(aln_s3.rbit & (aln_s3.sticky | aln_s3.m[0]));
		eb = 14'(aln_s3.eo);
		if (is_f64 ? mr[53] : mr[24]) begin
			mr = mr >> 1;
			eb = eb + 14'sd1;
		end
		biased = (is_f64 ? mr[52] : mr[23]) ? (eb + (is_f64 ? 14'sd1023 : 14'sd127)) : 14'sd0;
		case (aln_s3.tgt[1:0])
			2'd0: wm = 64'h0000_0000_0000_00ff;
			2'd1: wm = 64'h0000_0000_0000_ffff;
			2'd2: wm = 64'h0000_0000_ffff_ffff;
			default: wm = '1;
		endcase
		posmax = aln_s3.tgt[2] ? wm : (wm >> 1);
		negmax = aln_s3.tgt[2] ? 64'd0 : ((wm >> 1) + 64'd1);
		mag = aln_s3.m;
		over = aln_s3.neg ? (mag > negmax) : (mag > posmax);
		if (aln_s3.bad) begin
			r.status = ST_BAD;
		end else if (aln_s3.tgt == T_F32) begin
			r.result[31] = aln_s3.neg;
			case (aln_s3.cls)
				CLS_ZERO: r.status = ST_EXACT;
				CLS_INF: r.result[30:23] = 8'hff;
				CLS_NAN: begin
					// The payload arrives shifted right by 40; keep its top bits.
					r.result[30:22] = 9'h1ff;
					r.result[21:0] = aln_s3.m[22:1];
				end
				default: begin
					if (biased >= 14'sd255) begin
						r.result[30:23] = 8'hff;
						r.status = ST_SAT;
					end else begin
						r.result[30:23] = biased[7:0];
						r.result[22:0] = mr[22:0];
						r.status = inexact ? ST_INEX : ST_EXACT;
					end
				end
			endcase
		end else if (is_f64) begin
			r.result[63] = aln_s3.neg;
			case (aln_s3.cls)
				CLS_ZERO: r.status = ST_EXACT;
				CLS_INF: r.result[62:52] = 11'h7ff;
				CLS_NAN: begin
					// The payload arrives shifted right by 11; keep its top bits.
					r.result[62:51] = 12'hfff;
					r.result[50:0] = aln_s3.m[51:1];
				end
				default: begin
					if (biased >= 14'sd2047) begin
						r.result[62:52] = 11'h7ff;
						r.status = ST_SAT;
					end else begin
						r.result[62:52] = biased[10:0];
						r.result[51:0] = mr[51:0];
						r.status = inexact ? ST_INEX : ST_EXACT;
					end
				end
			endcase
		end else begin
			case (aln_s3.cls)
				CLS_ZERO: r.status = ST_EXACT;
				CLS_NAN: r.status = ST_NAN;
				default: begin
					if (aln_s3.cls == CLS_INF || aln_s3.big || over) begin
						mag = aln_s3.neg ? negmax : posmax;
						r.status = ST_SAT;
					end else begin
						r.status = inexact ? ST_INEX : ST_EXACT;
					end
					r.result = (aln_s3.neg ? (64'd0 - mag) : mag) & wm;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= r;
		end
	end

endmodule

/* rtl/numeric_type_converter.sv */
// Converts one 64-bit raw value between signed and unsigned 8/16/32/64-bit
// integers and IEEE binary32/binary64. Float targets round to nearest even
// and overflow to infinity; integer targets truncate toward zero and
// saturate, and NaN to an integer gives zero. A type code above 9 gives a
// zero result with the bad-type status. The unit is a four-stage pipeline
// (decode, normalize, align, round and pack): it takes one transfer per
// cycle when the output side is not stalled. Each stage holds its item
// under back-pressure, so bubbles are squeezed out and nothing is lost.
module numeric_type_converter import ntc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// source_type[3:0], source_bits[67:4], target_type[71:68]
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_bits[63:0], status[66:64], zero fill above
	output logic [71:0] m_tdata
);

	logic v1_q, v2_q, v3_q, v4_q;
	logic en1, en2, en3, en4;
	dec_t dec_s1;
	nrm_t nrm_s2;
	aln_t aln_s3;
	res_t res_s4;

	// A stage loads when it is empty or its content moves on.
	assign en4 = ~v4_q | m_tready;
	assign en3 = ~v3_q | en4;
	assign en2 = ~v2_q | en3;
	assign en1 = ~v1_q | en2;
	assign s_tready = en1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (en1) v1_q <= s_tvalid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
		end
	end

	ntc_decode_stage u_dec (
		.clk         (clk),
		.en          (en1),
		.source_type (s_tdata[3:0]),
		.source_bits (s_tdata[67:4]),
		.target_type (s_tdata[71:68]),
		.dec_s1      (dec_s1)
	);

	ntc_norm_stage u_nrm (
		.clk    (clk),
		.en     (en2),
		.dec_s1 (dec_s1),
		.nrm_s2 (nrm_s2)
	);

	ntc_align_stage u_aln (
		.clk    (clk),
		.en     (en3),
		.nrm_s2 (nrm_s2),
		.aln_s3 (aln_s3)
	);

	ntc_round_stage u_rnd (
		.clk    (clk),
		.en     (en4),
		.aln_s3 (aln_s3),
		.res_s4 (res_s4)
	);

	assign m_tvalid = v4_q;
	assign m_tdata = {5'd0, res_s4.status, res_s4.result};

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import ntc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 950;
	localparam logic [2:0] ST_NONE = 3'd7;

	// One directed row: types, raw value and, where obvious, the typed-in answer.
	typedef struct {
		logic [3:0]  src;
		logic [63:0] bits;
		logic [3:0]  tgt;
		logic        known;
		logic [63:0] res;
		logic [2:0]  st;
	} conv_row_t;

	typedef struct {
		logic [63:0] res;
		logic [2:0]  st;
	} conv_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;

	conv_out_t   expected_q[$];
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned sent_count;
	int unsigned got_count;
	bit          stim_done;
	bit          hold_off;

	numeric_type_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Exact value of a source: class, sign, magnitude significand and exponent.
	typedef struct {
		logic [1:0]  cls;
		logic        neg;
		logic [63:0] mant;
		int          ex;
	} exact_t;

	function automatic int bit_length(logic [63:0] v);
		int n;
		n = 0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = i + 1;
		end
		return n;
	endfunction

	function automatic logic [63:0] low_mask(int w);
		return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	function automatic exact_t unpack_float(logic [63:0] raw, int eb, int fb);
		exact_t x;
		logic [63:0] v, e, f;
		int bias;
		v = raw & low_mask(1 + eb + fb);
		e = (v >> fb) & low_mask(eb);
		f = v & low_mask(fb);
		bias = (1 << (eb - 1)) - 1;
		x.neg = v[eb + fb];
		x.ex = 0;
		if (e == low_mask(eb)) begin
			x.cls = (f != 0) ? CLS_NAN : CLS_INF;
			x.mant = f << (64 - fb);
		end else if (e == 0) begin
			x.cls = (f != 0) ? CLS_FIN : CLS_ZERO;
			x.mant = f;
			x.ex = 1 - bias - fb;
		end else begin
			x.cls = CLS_FIN;
			x.mant = f | (64'd1 << fb);
			x.ex = int'(e) - bias - fb;
		end
		return x;
	endfunction

	function automatic exact_t unpack_source(logic [3:0] src, logic [63:0] raw);
		exact_t x;
		logic [63:0] v;
		int w;
		if (src == T_F32) return unpack_float(raw, 8, 23);
		if (src == T_F64) return unpack_float(raw, 11, 52);
		w = 8 << src[1:0];
		v = raw & low_mask(w);
		if (src < T_U8 && w < 64 && v[w - 1]) v = v | ~low_mask(w);
		x.neg = (src < T_U8) ? v[63] : 1'b0;
		x.mant = x.neg ? -v : v;
		x.ex = 0;
		x.cls = (x.mant != 0) ? CLS_FIN : CLS_ZERO;
		if (x.mant == 0) x.neg = 1'b0;
		return x;
	endfunction

	// Round to nearest even into a float format; overflow goes to infinity.
	function automatic conv_out_t round_to_float(exact_t x, int eb, int fb);
		conv_out_t o;
		logic [63:0] sgn, emax_b, m, rem, half, biased;
		int bias, emin, e, q, sh;
		logic inexact;
		sgn = 64'(x.neg) << (eb + fb);
		emax_b = low_mask(eb);
		bias = (1 << (eb - 1)) - 1;
		emin = 1 - bias;
		o.st = ST_EXACT;
		rem = 0;
		inexact = 1'b0;
		if (x.cls == CLS_ZERO) begin
			o.res = sgn;
			return o;
		end
		if (x.cls == CLS_INF) begin
			o.res = sgn | (emax_b << fb);
			return o;
		end
		if (x.cls == CLS_NAN) begin
			o.res = sgn | (emax_b << fb) | (x.mant >> (64 - fb)) | (64'd1 << (fb - 1));
			return o;
		end
		e = x.ex + bit_length(x.mant) - 1;
		q = (e < emin) ? emin - fb : e - fb;
		sh = q - x.ex;
		if (sh <= 0) begin
			m = x.mant << (-sh);
		end else if (sh > 64) begin
			m = 0;
			inexact = 1'b1;
		end else begin
			if (sh == 64) begin
				m = 0;
				rem = x.mant;
			end else begin
				m = x.mant >> sh;
				rem = x.mant & low_mask(sh);
			end
			half = 64'd1 << (sh - 1);
			inexact = (rem != 0);
			if (rem > half || (rem == half && m[0])) m = m + 1;
		end
		if ((m >> (fb + 1)) != 0) begin
			m = m >> 1;
			q = q + 1;
		end
		biased = ((m >> fb) != 0) ? 64'(q + fb + bias) : 64'd0;
		if (biased >= emax_b) begin
			o.st = ST_SAT;
			o.res = sgn | (emax_b << fb);
			return o;
		end
		o.st = inexact ? ST_INEX : ST_EXACT;
		o.res = sgn | (biased << fb) | (m & low_mask(fb));
		return o;
	endfunction

	// Truncate toward zero into an integer type, saturating out of range.
	function automatic conv_out_t truncate_to_int(exact_t x, logic [3:0] tgt);
		conv_out_t o;
		logic [63:0] posmax, negmax, mag;
		logic lost, big;
		int w;
		w = 8 << tgt[1:0];
		posmax = (tgt < T_U8) ? low_mask(w - 1) : low_mask(w);
		negmax = (tgt < T_U8) ? (64'd1 << (w - 1)) : 64'd0;
		mag = 0;
		lost = 1'b0;
		big = 1'b0;
		o.st = ST_EXACT;
		o.res = 0;
		if (x.cls == CLS_ZERO) return o;
		if (x.cls == CLS_NAN) begin
			o.st = ST_NAN;
			return o;
		end
		if (x.cls == CLS_INF) begin
			big = 1'b1;
		end else if (x.ex >= 0) begin
			if (bit_length(x.mant) + x.ex > 64) big = 1'b1;
			else mag = x.mant << x.ex;
		end else if (-x.ex >= 64) begin
			lost = (x.mant != 0);
		end else begin
			mag = x.mant >> (-x.ex);
			lost = (x.mant & low_mask(-x.ex)) != 0;
		end
		if (!big) big = x.neg ? (mag > negmax) : (mag > posmax);
		if (big) begin
			o.st = ST_SAT;
			mag = x.neg ? negmax : posmax;
		end else begin
			o.st = lost ? ST_INEX : ST_EXACT;
		end
		o.res = (x.neg ? -mag : mag) & low_mask(w);
		return o;
	endfunction

	function automatic conv_out_t convert_value(logic [3:0] src, logic [63:0] raw,
			logic [3:0] tgt);
		conv_out_t o;
		exact_t x;
		if (src > T_F64 || tgt > T_F64) begin
			o.res = 0;
			o.st = ST_BAD;
			return o;
		end
		x = unpack_source(src, raw);
		if (tgt == T_F32) return round_to_float(x, 8, 23);
		if (tgt == T_F64) return round_to_float(x, 11, 52);
		return truncate_to_int(x, tgt);
	endfunction

	// Random raw value shaped for the source type: edges, float fields, noise.
	function automatic logic [63:0] pick_bits(logic [3:0] src);
		logic [63:0] r;
		int k;
		r = {$urandom, $urandom};
		k = $urandom_range(0, 9);
		if (src == T_F32 && k < 6) begin
			case ($urandom_range(0, 4))
				0: r[30:23] = 8'hff;
				1: r[30:23] = 8'h00;
				2: r[30:23] = 8'(127 + $urandom_range(0, 66) - 2);
				3: r[30:23] = 8'(127 - $urandom_range(0, 30));
				default: r[22:0] = r[22:0] & {23{1'b0}} | (23'd1 << $urandom_range(0, 22));
			endcase
		end else if (src == T_F64 && k < 7) begin
			case ($urandom_range(0, 5))
				0: r[62:52] = 11'h7ff;
				1: r[62:52] = 11'h000;
				2: r[62:52] = 11'(1023 + $urandom_range(0, 66) - 2);
				3: r[62:52] = 11'(1023 - $urandom_range(0, 60));
				4: r[62:52] = 11'(896 + $urandom_range(0, 260));
				default: r[51:0] = (52'd1 << $urandom_range(0, 51)) - 52'($urandom_range(0, 1));
			endcase
			if ($urandom_range(0, 3) == 0) r[28:0] = '0;
		end else if (k < 3) begin
			r = 64'd1 << $urandom_range(0, 63);
			if ($urandom_range(0, 1)) r = r - 64'd1;
			if ($urandom_range(0, 1)) r = -r;
		end
		return r;
	endfunction

	function automatic logic [3:0] pick_type();
		return ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
			: 4'($urandom_range(0, 9));
	endfunction

	// Send one transfer: bursts with random gaps, holding tvalid across items.
	task automatic send_item(logic [3:0] src, logic [63:0] raw, logic [3:0] tgt);
		if ($urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {tgt, raw, src};
		expected_q.push_back(convert_value(src, raw, tgt));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_count++;
	endtask

	// Receiver: a stall pattern of its own, plus one long hold-off.
	initial begin
		int phase;
		phase = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase++;
			if (hold_off) m_tready <= 1'b0;
			else if (phase % 512 < 128) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Compare every output transfer with the oldest expectation.
	always @(posedge clk) begin
		conv_out_t exp_out;
		if (m_tvalid && m_tready) begin
			got_count++;
			if (expected_q.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				error_count++;
			end else begin
				exp_out = expected_q.pop_front();
				if (m_tdata[63:0] !== exp_out.res) begin
					$error("result_bits expected %h actual %h", exp_out.res, m_tdata[63:0]);
					error_count++;
				end
				if (m_tdata[66:64] !== exp_out.st) begin
					$error("status expected %0d actual %0d", exp_out.st, m_tdata[66:64]);
					error_count++;
				end
			end
		end
	end

	// Cycle counter with the timeout.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Long hold-off on the output while the sender keeps offering.
	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		wait (sent_count >= 300);
		hold_off = 1'b1;
		repeat (60) @(posedge clk);
		hold_off = 1'b0;
	end

	// Directed table, then random traffic, then drain and verdict.
	initial begin
		conv_row_t rows[$];
		conv_out_t o;
		logic [3:0] src;
		rows = '{
			'{T_U8, 64'hffff_ffff_ffff_ff00, T_I8, 1'b1, 64'h0, ST_EXACT},
			'{T_I8, 64'h80, T_I64, 1'b1, 64'hffff_ffff_ffff_ff80, ST_EXACT},
			'{T_U64, 64'hffff_ffff_ffff_ffff, T_I64, 1'b1, 64'h7fff_ffff_ffff_ffff, ST_SAT},
			'{T_I64, 64'h8000_0000_0000_0000, T_U32, 1'b1, 64'h0, ST_SAT},
			'{T_I32, 64'h7fff_ffff, T_I16, 1'b1, 64'h7fff, ST_SAT},
			'{T_F32, 64'h7fc0_0000, T_I32, 1'b1, 64'h0, ST_NAN},
			'{T_F64, 64'hfff0_0000_0000_0000, T_I16, 1'b1, 64'h8000, ST_SAT},
			'{T_F32, 64'h7f80_0000, T_U8, 1'b1, 64'hff, ST_SAT},
			'{T_F64, 64'hbfe0_0000_0000_0000, T_U8, 1'b1, 64'h0, ST_INEX},
			'{T_F64, 64'hbff0_0000_0000_0000, T_U8, 1'b1, 64'h0, ST_SAT},
			'{T_F64, 64'h3ff8_0000_0000_0000, T_I32, 1'b1, 64'h1, ST_INEX},
			'{T_F64, 64'h7fef_ffff_ffff_ffff, T_F32, 1'b1, 64'h7f80_0000, ST_SAT},
			'{T_F64, 64'h8000_0000_0000_0000, T_F32, 1'b1, 64'h8000_0000, ST_EXACT},
			'{T_F32, 64'hff80_0001, T_F64, 1'b0, 64'h0, ST_NONE},
			'{T_F64, 64'h0000_0000_0000_0001, T_F32, 1'b1, 64'h0, ST_INEX},
			'{T_F64, 64'h36a0_0000_0000_0001, T_F32, 1'b0, 64'h0, ST_NONE},
			'{T_F32, 64'h0000_0001, T_F64, 1'b0, 64'h0, ST_NONE},
			'{T_U64, 64'hffff_ffff_ffff_ffff, T_F32, 1'b0, 64'h0, ST_NONE},
			'{T_I64, 64'h8000_0000_0000_0000, T_F64, 1'b0, 64'h0, ST_NONE},
			'{T_U32, 64'h0100_0001, T_F32, 1'b0, 64'h0, ST_NONE},
			'{T_I16, 64'hffff_ffff_ffff_0000, T_F32, 1'b1, 64'h0, ST_EXACT},
			'{4'd10, 64'h1234, T_I8, 1'b1, 64'h0, ST_BAD},
			'{T_I8, 64'h1234, 4'd15, 1'b1, 64'h0, ST_BAD}
		};
		error_count = 0;
		cycle_count = 0;
		sent_count = 0;
		got_count = 0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: the typed answer must agree with the predictor too.
		foreach (rows[i]) begin
			if (rows[i].known) begin
				o = convert_value(rows[i].src, rows[i].bits, rows[i].tgt);
				if (o.res !== rows[i].res || o.st !== rows[i].st) begin
					$error("row %0d table answer %h/%0d disagrees with predictor %h/%0d",
						i, rows[i].res, rows[i].st, o.res, o.st);
					error_count++;
				end
			end
			send_item(rows[i].src, rows[i].bits, rows[i].tgt);
		end

		// Random conversions.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			src = pick_type();
			send_item(src, pick_bits(src), pick_type());
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Converted %0d items across all ten type codes and invalid codes,",
			sent_count);
		$display("with %0d results checked under bursty input and stalled output.", got_count);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
